// ===== hdl/htbl_pkg.sv =====
// Package with shared constants, types and a helper function for the token bucket limiter.
`default_nettype none
package htbl_pkg;
  localparam int unsigned FlowEntries = 1024;
  localparam int unsigned TypeEntries = 256;
  localparam int unsigned FlowAw = $clog2(FlowEntries);
  localparam int unsigned TypeAw = $clog2(TypeEntries);
  localparam int unsigned TokW = 48;
  localparam int unsigned CfgIdxW = 3;
  localparam logic [63:0] Golden = 64'h9e3779b97f4a7c15;
  localparam logic [TokW-1:0] OneToken = 48'd65536;
  localparam logic [TokW-1:0] Max48 = {TokW{1'b1}};

  localparam logic [CfgIdxW-1:0] RegPacketRate = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPacketBurst = 3'd1;
  localparam logic [CfgIdxW-1:0] RegByteRate = 3'd2;
  localparam logic [CfgIdxW-1:0] RegByteBurst = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLifetime = 3'd4;
  localparam logic [CfgIdxW-1:0] RegTypeRate = 3'd5;
  localparam logic [CfgIdxW-1:0] RegTypeBurst = 3'd6;

  localparam logic [1:0] DenyNone = 2'd0;
  localparam logic [1:0] DenyPacket = 2'd1;
  localparam logic [1:0] DenyByte = 2'd2;
  localparam logic [1:0] DenyType = 2'd3;

  typedef struct packed {
    logic [63:0] key_hash;
    logic [47:0] now_ms;
    logic [15:0] byte_cost;
    logic [7:0] type_code;
  } req_t;

  typedef struct packed {
    logic allowed;
    logic [1:0] deny_reason;
    logic table_full;
  } rsp_t;

  typedef struct packed {
    logic [47:0] packet_rate;
    logic [47:0] packet_burst;
    logic [47:0] byte_rate;
    logic [47:0] byte_burst;
    logic [47:0] entry_lifetime;
    logic [47:0] type_rate;
    logic [47:0] type_burst;
  } cfg_t;

  function automatic logic [TokW-1:0] cap_add(input logic [TokW-1:0] tokens,
                                              input logic [TokW-1:0] add,
                                              input logic [TokW-1:0] burst);
    logic [TokW:0] sum;
    sum = {1'b0, tokens} + {1'b0, add};
    cap_add = (sum < {1'b0, burst}) ? sum[TokW-1:0] : burst;
  endfunction
endpackage
`default_nettype wire

// ===== hdl/htbl_if.sv =====
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface htbl_req_if;
  import htbl_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface htbl_rsp_if;
  import htbl_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/htbl_cfg.sv =====
// Configuration register file of the limiter.
`default_nettype none
module htbl_cfg
  import htbl_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [47:0] cfg_data_i,
  output cfg_t cfg_o
);
  cfg_t cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
      cfg_q.entry_lifetime <= 48'd60000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegPacketRate: cfg_q.packet_rate <= cfg_data_i;
        RegPacketBurst: cfg_q.packet_burst <= cfg_data_i;
        RegByteRate: cfg_q.byte_rate <= cfg_data_i;
        RegByteBurst: cfg_q.byte_burst <= cfg_data_i;
        RegLifetime: cfg_q.entry_lifetime <= cfg_data_i;
        RegTypeRate: cfg_q.type_rate <= cfg_data_i;
        RegTypeBurst: cfg_q.type_burst <= cfg_data_i;
        default: ;
      endcase
    end
  end
  assign cfg_o = cfg_q;
endmodule
`default_nettype wire

// ===== hdl/htbl_refill.sv =====
// Saturating refill unit: elapsed times rate in 24-bit halves, registered, then cap at burst.
`default_nettype none
module htbl_refill
  import htbl_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic [47:0] elapsed_i,
  input  wire logic [47:0] rate_i,
  input  wire logic [47:0] tokens_i,
  input  wire logic [47:0] burst_i,
  output logic [47:0] tokens_o
);
  logic [47:0] ll_q, lh_q, hl_q, hh_q;
  logic [47:0] tok_q, burst_q;
  logic [49:0] mid;
  logic [50:0] total;
  logic over;
  always_ff @(posedge clk_i) begin
    ll_q <= elapsed_i[23:0] * rate_i[23:0];
    lh_q <= elapsed_i[23:0] * rate_i[47:24];
    hl_q <= elapsed_i[47:24] * rate_i[23:0];
    hh_q <= elapsed_i[47:24] * rate_i[47:24];
    tok_q <= tokens_i;
    burst_q <= burst_i;
  end
  always_comb begin
    mid = {2'b0, lh_q} + {2'b0, hl_q} + {26'b0, ll_q[47:24]};
    total = {1'b0, mid[25:0], ll_q[23:0]};
    over = (hh_q != '0) || (mid[49:24] != '0);
    tokens_o = cap_add(tok_q, (over || total[50:48] != '0) ? Max48 : total[47:0],
                       burst_q);
  end
endmodule
`default_nettype wire

// ===== hdl/htbl_core.sv =====
// Sequencer with flow and type memories doing probe, refill, check and write-back.
`default_nettype none
module htbl_core
  import htbl_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cfg_t cfg_i,
  htbl_req_if.sink req,
  htbl_rsp_if.source rsp
);
  localparam logic [3:0] StIdle = 4'd0, StFRd = 4'd1, StFChk = 4'd2,
    StFRef = 4'd3, StFRes = 4'd4, StTRd = 4'd5, StTChk = 4'd6,
    StTRef = 4'd7, StTRes = 4'd8, StOut = 4'd9, StClr = 4'd10;
  localparam int unsigned FlowW = 1 + 64 + 48 + 48 + 48;
  localparam int unsigned TypeW = 64 + 48 + 48;

  logic [3:0] st_q, st_d;
  req_t r_q;
  logic [63:0] tkey_q;
  logic [FlowAw:0] fcnt_q;
  logic [TypeAw:0] tcnt_q;
  logic [FlowAw-1:0] fidx_q;
  logic [TypeAw-1:0] tidx_q;
  logic [TypeEntries-1:0] tval_q;
  logic [FlowW-1:0] fmem [FlowEntries];
  logic [TypeW-1:0] tmem [TypeEntries];
  logic [FlowW-1:0] frd_q;
  logic [TypeW-1:0] trd_q;
  logic tv_q;
  logic [47:0] ptok_q, btok_q, ttok_q, time_q;
  rsp_t res_q;
  logic out_v_q;

  logic [63:0] ekey;
  logic [47:0] etime, ep, eb, et, age, el, ref_a, ref_b, ref_ra, ref_rb, ref_ba, ref_bb;
  logic [47:0] ref_ta, ref_tb, new_a, new_b;
  logic valid_e, expired, match, use_slot;
  logic [47:0] cost48;

  assign cost48 = {16'b0, r_q.byte_cost, 16'b0};
  assign ekey = (st_q == StFChk) ? frd_q[FlowW-2 -: 64] : trd_q[TypeW-1 -: 64];
  assign etime = (st_q == StFChk) ? frd_q[143:96] : trd_q[95:48];
  assign ep = frd_q[95:48];
  assign eb = frd_q[47:0];
  assign et = trd_q[47:0];
  assign valid_e = (st_q == StFChk) ? frd_q[FlowW-1] : tv_q;
  assign age = r_q.now_ms - etime;
  assign expired = valid_e && (age > cfg_i.entry_lifetime);
  assign match = valid_e && !expired &&
                 (ekey == ((st_q == StFChk) ? r_q.key_hash : tkey_q));
  assign use_slot = !valid_e || match || expired;
  assign el = (r_q.now_ms > time_q) ? r_q.now_ms - time_q : '0;

  always_comb begin
    ref_ta = ptok_q; ref_ra = cfg_i.packet_rate; ref_ba = cfg_i.packet_burst;
    ref_tb = btok_q; ref_rb = cfg_i.byte_rate; ref_bb = cfg_i.byte_burst;
    if (st_q == StTRef || st_q == StTRes) begin
      ref_ta = ttok_q; ref_ra = cfg_i.type_rate; ref_ba = cfg_i.type_burst;
    end
    ref_a = ref_ta;
    ref_b = ref_tb;
  end
  htbl_refill u_ref_a (.clk_i, .elapsed_i(el), .rate_i(ref_ra), .tokens_i(ref_a),
    .burst_i(ref_ba), .tokens_o(new_a));
  htbl_refill u_ref_b (.clk_i, .elapsed_i(el), .rate_i(ref_rb), .tokens_i(ref_b),
    .burst_i(ref_bb), .tokens_o(new_b));

  logic pk_deny, by_deny, ty_on;
  assign pk_deny = (cfg_i.packet_rate != '0) && (new_a < OneToken);
  assign by_deny = (cfg_i.byte_rate != '0) && (new_b < cost48);
  assign ty_on = (cfg_i.type_rate != '0) || (cfg_i.type_burst != '0);

  logic fwe, twe;
  logic [FlowW-1:0] fwd;
  logic [TypeW-1:0] twd;
  logic [47:0] pfin, bfin, pbase, bbase;
  always_comb begin
    st_d = st_q;
    fwe = 1'b0; twe = 1'b0;
    pbase = (st_q == StFRes) ? new_a : ptok_q;
    bbase = (st_q == StFRes) ? new_b : btok_q;
    pfin = pbase; bfin = bbase;
    if (cfg_i.packet_rate != '0) pfin = pbase - OneToken;
    if (cfg_i.byte_rate != '0) bfin = bbase - cost48;
    fwd = {1'b1, r_q.key_hash, r_q.now_ms, new_a, new_b};
    twd = {tkey_q, r_q.now_ms, new_a - OneToken};
    unique case (st_q)
      StClr: begin
        fwe = 1'b1;
        fwd = '0;
        if (fidx_q == FlowAw'(FlowEntries - 1)) st_d = StIdle;
      end
      StIdle: if (req.valid && !out_v_q) st_d = StFRd;
      StFRd: st_d = StFChk;
      StFChk: begin
        if (use_slot) st_d = StFRef;
        else if (fcnt_q == (FlowAw+1)'(FlowEntries - 1)) st_d = StOut;
        else st_d = StFRd;
      end
      StFRef: st_d = StFRes;
      StFRes: begin
        fwe = 1'b1;
        if (pk_deny || by_deny || !ty_on) begin
          if (!(pk_deny || by_deny)) fwd = {1'b1, r_q.key_hash, r_q.now_ms, pfin, bfin};
          st_d = StOut;
        end else st_d = StTRd;
      end
      StTRd: st_d = StTChk;
      StTChk: begin
        if (use_slot) st_d = StTRef;
        else if (tcnt_q == (TypeAw+1)'(TypeEntries - 1)) begin
          fwe = 1'b1;
          fwd = {1'b1, r_q.key_hash, r_q.now_ms, pfin, bfin};
          st_d = StOut;
        end else st_d = StTRd;
      end
      StTRef: st_d = StTRes;
      StTRes: begin
        twe = 1'b1;
        if (new_a < OneToken) twd = {tkey_q, r_q.now_ms, new_a};
        else begin
          fwe = 1'b1;
          fwd = {1'b1, r_q.key_hash, r_q.now_ms, pfin, bfin};
        end
        st_d = StOut;
      end
      StOut: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    frd_q <= fmem[fidx_q];
    trd_q <= tmem[tidx_q];
    if (fwe) fmem[fidx_q] <= fwd;
    if (twe) tmem[tidx_q] <= twd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClr;
      tval_q <= '0;
      out_v_q <= 1'b0;
      res_q <= '0;
      fcnt_q <= '0;
      tcnt_q <= '0;
      fidx_q <= '0;
      tidx_q <= '0;
      tv_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (rsp.ready) out_v_q <= 1'b0;
      unique case (st_q)
        StClr: fidx_q <= fidx_q + 1'b1;
        StIdle: if (req.valid && !out_v_q) begin
          fidx_q <= req.payload.key_hash[FlowAw-1:0];
          fcnt_q <= '0;
          res_q <= '{allowed: 1'b1, deny_reason: DenyNone, table_full: 1'b0};
        end
        StFChk: if (use_slot) begin
        end else if (fcnt_q == (FlowAw+1)'(FlowEntries - 1)) begin
          res_q.table_full <= 1'b1;
        end else begin
          fidx_q <= fidx_q + 1'b1;
          fcnt_q <= fcnt_q + 1'b1;
        end
        StFRes: begin
          tidx_q <= tkey_q[TypeAw-1:0];
          tcnt_q <= '0;
          if (pk_deny) res_q <= '{allowed: 1'b0, deny_reason: DenyPacket, table_full: 1'b0};
          else if (by_deny) res_q <= '{allowed: 1'b0, deny_reason: DenyByte, table_full: 1'b0};
        end
        StTRd: tv_q <= tval_q[tidx_q];
        StTChk: if (use_slot) tval_q[tidx_q] <= 1'b1;
          else if (tcnt_q != (TypeAw+1)'(TypeEntries - 1)) begin
            tidx_q <= tidx_q + 1'b1;
            tcnt_q <= tcnt_q + 1'b1;
          end
        StTRes: if (new_a < OneToken)
          res_q <= '{allowed: 1'b0, deny_reason: DenyType, table_full: 1'b0};
        StOut: out_v_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // Payload registers for the running transaction and the loaded entry.
  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && req.valid && !out_v_q) begin
      r_q <= req.payload;
      tkey_q <= req.payload.key_hash ^ (64'(req.payload.type_code) * Golden);
    end
    if (st_q == StFChk) begin
      time_q <= match ? etime : r_q.now_ms;
      ptok_q <= match ? ep : cfg_i.packet_burst;
      btok_q <= match ? eb : cfg_i.byte_burst;
    end
    if (st_q == StTChk) begin
      time_q <= match ? etime : r_q.now_ms;
      ttok_q <= match ? et : cfg_i.type_burst;
    end
    if (st_q == StFRes) begin
      ptok_q <= new_a;
      btok_q <= new_b;
    end
  end

  assign req.ready = (st_q == StIdle) && !out_v_q;
  assign rsp.valid = out_v_q;
  assign rsp.payload = res_q;
endmodule
`default_nettype wire

// ===== hdl/hashed_token_bucket_limiter_unit.sv =====
// Top level of the hashed token bucket limiter.
// After reset the block clears its flow table before it takes the first request
// transaction. One message is handled at a time. Each probe of the flow table is a
// memory read, then a compare, followed by the refill and check of the found entry,
// and the type table is probed, refilled and checked the same way when a type limit
// is set and the flow checks pass. A result waits in its output register and the next
// request is taken in the cycle after it is gone.
`default_nettype none
module hashed_token_bucket_limiter_unit
  import htbl_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [47:0] cfg_data_i,
  htbl_req_if.sink req,
  htbl_rsp_if.source rsp
);
  cfg_t cfg;
  htbl_cfg u_cfg (.clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .cfg_o(cfg));
  htbl_core u_core (.clk_i, .rst_ni, .cfg_i(cfg), .req, .rsp);
endmodule
`default_nettype wire

// ===== hdl/htbl_checker.sv =====
// Port-level checker for the limiter and its bind.
`default_nettype none
module htbl_checker
  import htbl_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input rsp_t out_payload
);
  a_allow_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_payload.allowed == (out_payload.deny_reason == DenyNone)))
    else $error("allowed and deny reason disagree");
  a_full_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_payload.table_full |-> out_payload.allowed)
    else $error("full table must fail open");
  a_no_take_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready)
    else $error("request taken while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("result dropped while stalled");
endmodule

bind hashed_token_bucket_limiter_unit htbl_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(req.valid), .in_ready(req.ready),
  .out_valid(rsp.valid), .out_ready(rsp.ready), .out_payload(rsp.payload));
`default_nettype wire

// ===== verif/htbl_scoreboard.sv =====
// Scoreboard for the token bucket limiter: flow and type tables with result prediction.
package htbl_scoreboard_pkg;
  import htbl_pkg::*;

  class limiter_scoreboard;
    cfg_t cfg;
    bit flow_used[FlowEntries];
    logic [63:0] flow_key[FlowEntries];
    logic [47:0] flow_stamp[FlowEntries];
    logic [47:0] flow_pkt[FlowEntries];
    logic [47:0] flow_byt[FlowEntries];
    bit type_used[TypeEntries];
    logic [63:0] type_key[TypeEntries];
    logic [47:0] type_stamp[TypeEntries];
    logic [47:0] type_tok[TypeEntries];
    rsp_t pending_verdicts[$];
    int errors;

    function new();
      cfg = '0;
      cfg.entry_lifetime = 48'd60000;
      errors = 0;
      foreach (flow_used[i]) flow_used[i] = 0;
      foreach (type_used[i]) type_used[i] = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [47:0] val);
      case (idx)
        RegPacketRate: cfg.packet_rate = val;
        RegPacketBurst: cfg.packet_burst = val;
        RegByteRate: cfg.byte_rate = val;
        RegByteBurst: cfg.byte_burst = val;
        RegLifetime: cfg.entry_lifetime = val;
        RegTypeRate: cfg.type_rate = val;
        RegTypeBurst: cfg.type_burst = val;
        default: ;
      endcase
    endfunction

    function logic [47:0] refill(logic [47:0] tok, logic [47:0] last, logic [47:0] now,
                                 logic [47:0] rate, logic [47:0] burst);
      logic [47:0] elapsed;
      logic [95:0] prod;
      logic [48:0] sum;
      logic [47:0] add;
      elapsed = (now > last) ? now - last : 48'd0;
      prod = elapsed * rate;
      add = (prod > {48'd0, Max48}) ? Max48 : prod[47:0];
      sum = {1'b0, tok} + {1'b0, add};
      return (sum < {1'b0, burst}) ? sum[47:0] : burst;
    endfunction

    function void note_request(req_t r);
      rsp_t v;
      int slot, tslot, n, s;
      bit fresh, expired, hit;
      logic [63:0] tkey;
      logic [47:0] cost;
      v = '0;
      v.allowed = 1;
      cost = {16'd0, r.byte_cost, 16'd0};
      slot = -1;
      for (n = 0; n < FlowEntries; n++) begin
        s = int'((r.key_hash % FlowEntries + n) % FlowEntries);
        expired = flow_used[s] && ((r.now_ms - flow_stamp[s]) > cfg.entry_lifetime);
        hit = flow_used[s] && flow_key[s] == r.key_hash && !expired;
        if (!flow_used[s] || hit || expired) begin
          fresh = !hit;
          if (fresh) begin
            flow_key[s] = r.key_hash;
            flow_stamp[s] = r.now_ms;
            flow_pkt[s] = cfg.packet_burst;
            flow_byt[s] = cfg.byte_burst;
          end
          flow_used[s] = 1;
          slot = s;
          break;
        end
      end
      if (slot < 0) begin
        v.table_full = 1;
        pending_verdicts.push_back(v);
        return;
      end
      flow_pkt[slot] = refill(flow_pkt[slot], flow_stamp[slot], r.now_ms,
                              cfg.packet_rate, cfg.packet_burst);
      flow_byt[slot] = refill(flow_byt[slot], flow_stamp[slot], r.now_ms,
                              cfg.byte_rate, cfg.byte_burst);
      flow_stamp[slot] = r.now_ms;
      if (cfg.packet_rate != 0 && flow_pkt[slot] < OneToken) begin
        v.allowed = 0; v.deny_reason = DenyPacket;
        pending_verdicts.push_back(v);
        return;
      end
      if (cfg.byte_rate != 0 && flow_byt[slot] < cost) begin
        v.allowed = 0; v.deny_reason = DenyByte;
        pending_verdicts.push_back(v);
        return;
      end
      if (cfg.type_rate != 0 || cfg.type_burst != 0) begin
        tkey = r.key_hash ^ (64'(r.type_code) * Golden);
        tslot = -1;
        for (n = 0; n < TypeEntries; n++) begin
          s = int'((tkey % TypeEntries + n) % TypeEntries);
          expired = type_used[s] && ((r.now_ms - type_stamp[s]) > cfg.entry_lifetime);
          hit = type_used[s] && type_key[s] == tkey && !expired;
          if (!type_used[s] || hit || expired) begin
            if (!hit) begin
              type_key[s] = tkey;
              type_stamp[s] = r.now_ms;
              type_tok[s] = cfg.type_burst;
            end
            type_used[s] = 1;
            tslot = s;
            break;
          end
        end
        if (tslot >= 0) begin
          type_tok[tslot] = refill(type_tok[tslot], type_stamp[tslot], r.now_ms,
                                   cfg.type_rate, cfg.type_burst);
          type_stamp[tslot] = r.now_ms;
          if (type_tok[tslot] < OneToken) begin
            v.allowed = 0; v.deny_reason = DenyType;
            pending_verdicts.push_back(v);
            return;
          end
          type_tok[tslot] -= OneToken;
        end
      end
      if (cfg.packet_rate != 0) flow_pkt[slot] -= OneToken;
      if (cfg.byte_rate != 0) flow_byt[slot] -= cost;
      pending_verdicts.push_back(v);
    endfunction

    function void check_result(rsp_t got);
      rsp_t exp_v;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, got);
        errors++;
        return;
      end
      exp_v = pending_verdicts.pop_front();
      if (got.allowed !== exp_v.allowed) begin
        $display("%0t: allowed expected %0b actual %0b", $realtime, exp_v.allowed,
                 got.allowed);
        errors++;
      end
      if (got.deny_reason !== exp_v.deny_reason) begin
        $display("%0t: deny_reason expected %0d actual %0d", $realtime,
                 exp_v.deny_reason, got.deny_reason);
        errors++;
      end
      if (got.table_full !== exp_v.table_full) begin
        $display("%0t: table_full expected %0b actual %0b", $realtime, exp_v.table_full,
                 got.table_full);
        errors++;
      end
    endfunction
  endclass
endpackage

// ===== verif/tb_hashed_token_bucket_limiter_unit.sv =====
// Testbench top for the hashed token bucket limiter: directed and random traffic.
module tb_hashed_token_bucket_limiter_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import htbl_pkg::*;
  import htbl_scoreboard_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [47:0] cfg_data_i = '0;
  htbl_req_if req();
  htbl_rsp_if rsp();

  hashed_token_bucket_limiter_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .req(req.sink), .rsp(rsp.source)
  );

  limiter_scoreboard board = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 0;
  int idle_cycles = 0;
  logic [47:0] clock_ms = 48'd1000;
  logic [63:0] key_pool[16];

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  initial begin
    req.valid = 0;
    req.payload = '0;
    rsp.ready = 0;
  end

  always @(posedge clk_i) begin
    if (req.valid && req.ready) board.note_request(req.payload);
    if (rsp.valid && rsp.ready) board.check_result(rsp.payload);
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WatchdogLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) rsp.ready <= 0;
    else rsp.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [47:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    board.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic drain();
    while (board.pending_verdicts.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic send_msg(logic [63:0] key, logic [47:0] now, logic [15:0] cost,
                          logic [7:0] mtype);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    req.valid <= 1;
    req.payload <= '{key_hash: key, now_ms: now, byte_cost: cost, type_code: mtype};
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    @(negedge clk_i);
    req.valid <= 0;
  endtask

  task automatic configure(logic [47:0] pr, logic [47:0] pb, logic [47:0] br,
                           logic [47:0] bb, logic [47:0] lt, logic [47:0] tr,
                           logic [47:0] tb);
    drain();
    write_reg(RegPacketRate, pr);
    write_reg(RegPacketBurst, pb);
    write_reg(RegByteRate, br);
    write_reg(RegByteBurst, bb);
    write_reg(RegLifetime, lt);
    write_reg(RegTypeRate, tr);
    write_reg(RegTypeBurst, tb);
  endtask

  task automatic random_msgs(int count);
    logic [63:0] key;
    logic [15:0] cost;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) key = {$urandom, $urandom};
      else key = key_pool[$urandom_range(15)];
      if ($urandom_range(19) == 0) clock_ms = 48'({$urandom, $urandom});
      else clock_ms = clock_ms + $urandom_range(3);
      cost = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(20));
      send_msg(key, clock_ms, cost, 8'($urandom_range(3) == 0 ? $urandom : $urandom_range(3)));
    end
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    key_pool[1] = key_pool[0] + FlowEntries;
    key_pool[2] = key_pool[0] + 2 * FlowEntries;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    send_msg(64'd0, 48'd0, 16'd0, 8'd0);
    send_msg(64'hFFFF_FFFF_FFFF_FFFF, Max48, 16'hFFFF, 8'hFF);
    configure(48'h1_0000, 48'h3_0000, 48'h10_0000, 48'h20_0000, 48'd50,
              48'h1_0000, 48'h2_0000);
    for (int i = 0; i < 5; i++) send_msg(key_pool[3], 48'd100, 16'd4, 8'd1);
    send_msg(key_pool[3], 48'd101, 16'hFFFF, 8'd2);
    send_msg(key_pool[3], 48'd103, 16'd1, 8'd1);
    send_msg(key_pool[3], 48'd90, 16'd1, 8'd1);
    send_msg(key_pool[3], 48'd500, 16'd1, 8'd1);
    send_msg(key_pool[0], 48'd600, 16'd1, 8'd7);
    send_msg(key_pool[1], 48'd600, 16'd1, 8'd7);
    send_msg(key_pool[2], 48'd600, 16'd1, 8'd7);
    configure(Max48, Max48, Max48, Max48, Max48, Max48, Max48);
    send_msg(key_pool[4], 48'd0, 16'hFFFF, 8'd0);
    send_msg(key_pool[4], Max48, 16'hFFFF, 8'hFF);
    configure(48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'h1_0000);
    send_msg(key_pool[5], 48'd10, 16'd1, 8'd3);
    send_msg(key_pool[5], 48'd10, 16'd1, 8'd3);

    configure(48'h8000, 48'h4_0000, 48'h40_0000, 48'h200_0000, 48'd20,
              48'h8000, 48'h3_0000);
    send_idle_pct = 32;
    recv_idle_pct = 48;
    random_msgs(290);
    fork
      begin
        recv_hold = 1;
        repeat (400) @(negedge clk_i);
        recv_hold = 0;
      end
      random_msgs(20);
    join
    configure(48'h2_0000, 48'h2_0000, 48'd0, 48'h10_0000, 48'd1000, 48'd0, 48'd0);
    send_idle_pct = 48;
    recv_idle_pct = 32;
    random_msgs(290);
    configure(48'h4000, 48'h1_8000, 48'h4_0000, 48'h8_0000, 48'd5,
              48'h1_0000, 48'h1_0000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_msgs(290);
    drain();
    if (board.errors == 0 && board.pending_verdicts.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
